[sv/signed_int_to_decimal_ascii_macros.svh]
// assertion macros for the checker file
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// same-cycle implication, disabled during reset
`define SITDA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sitda assertion failed");

// next-cycle implication, disabled during reset
`define SITDA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sitda assertion failed");

`endif

[sv/sitda_pkg.sv]
// ----------------------------------------------------------------------------
// sitda_pkg
// shared widths, character codes and control types for the decimal printer
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int VALUE_BITS = 32;
  // decimal digits of the largest magnitude, floor(n*log10(2)) + 1
  localparam int NDIG       = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int BCD_BITS   = NDIG * 4;
  localparam int IN_W       = ((VALUE_BITS + 7) / 8) * 8;
  localparam int CHAR_BITS  = 6;
  localparam int OUT_W      = 8;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int DL_W       = $clog2(NDIG + 1);

  localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 6'd45;
  localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 6'd48;

  typedef struct packed {
    logic load;
    logic next_digit;
  } dab_ctrl_t;

  typedef struct packed {
    logic       done;
    logic [3:0] top_digit;
  } dab_stat_t;

endpackage

[sv/sitda_dabble.sv]
// ----------------------------------------------------------------------------
// sitda_dabble
// bit-serial binary to bcd converter (shift and add 3) with a digit shifter
// ----------------------------------------------------------------------------
module sitda_dabble (
  input  logic                           clk,
  input  logic                           rst,
  input  sitda_pkg::dab_ctrl_t           ctrl,
  input  logic [sitda_pkg::VALUE_BITS-1:0] value,
  output sitda_pkg::dab_stat_t           stat
);
  import sitda_pkg::*;

  logic [VALUE_BITS-1:0] mag;
  logic [BCD_BITS-1:0]   bcd;
  logic [BCD_BITS-1:0]   adj;
  logic [CNT_W-1:0]      cnt;

  // every digit of 5 or more gets 3 added before the shift
  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      if (bcd[d*4 +: 4] >= 4'd5) begin
        adj[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
      end else begin
        adj[d*4 +: 4] = bcd[d*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.load) begin
      cnt <= CNT_W'(VALUE_BITS);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mag <= value;
      bcd <= '0;
    end else if (cnt != '0) begin
      bcd <= {adj[BCD_BITS-2:0], mag[VALUE_BITS-1]};
      mag <= {mag[VALUE_BITS-2:0], 1'b0};
    end else if (ctrl.next_digit) begin
      bcd <= {bcd[BCD_BITS-5:0], 4'd0};
    end
  end

  assign stat.done      = (cnt == '0);
  assign stat.top_digit = bcd[BCD_BITS-1 -: 4];

endmodule

[sv/signed_int_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// prints a signed integer as decimal ascii characters, most significant first
// ----------------------------------------------------------------------------
// usage:
//   s_* takes one request per number: tdata[31:0] is the signed value.
//   m_* gives one character per beat: tdata[5:0] is the ascii code (45 for
//   the minus sign, 48..57 for digits), tlast marks the final character.
//   leading zeros are dropped; zero prints as a single '0'.
// timing:
//   after a request the magnitude is shifted through a bcd register one bit
//   per cycle. leading zero digits are then dropped and characters leave at
//   one per cycle while the receiver is ready. s_tready is high only between
//   numbers; the next number can be taken while the final character still
//   waits in the output register.
// reset: rst (synchronous, active high) empties the output and returns to idle.
// stall: when m_tready is low the current character holds and emission pauses.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [sitda_pkg::IN_W-1:0]  s_tdata,   // [31:0] number
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [sitda_pkg::OUT_W-1:0] m_tdata,   // [5:0] char_code, [7:6] zero
  output logic                        m_tlast    // last_char
);
  import sitda_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SKIP = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [DL_W-1:0]       digits_left;
  logic [DL_W-1:0]       digits_left_next;
  logic                  neg_pending;
  logic                  neg_pending_next;
  logic [CHAR_BITS-1:0]  char_code;
  logic                  last_char;

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag_in;
  logic                  accept;
  logic                  out_free;
  logic                  out_load;
  logic [CHAR_BITS-1:0]  load_code;
  logic                  load_last;
  dab_ctrl_t             ctrl;
  dab_stat_t             stat;

  assign raw    = s_tdata[VALUE_BITS-1:0];
  assign mag_in = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next       = state;
    digits_left_next = digits_left;
    neg_pending_next = neg_pending;
    ctrl.load        = 1'b0;
    ctrl.next_digit  = 1'b0;
    out_load         = 1'b0;
    load_code        = ASCII_ZERO;
    load_last        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          ctrl.load        = 1'b1;
          neg_pending_next = raw[VALUE_BITS-1];
          state_next       = S_CONV;
        end
      end
      S_CONV: begin
        if (stat.done) begin
          digits_left_next = DL_W'(NDIG);
          state_next       = S_SKIP;
        end
      end
      S_SKIP: begin
        // drop leading zeros but keep at least one digit
        if (stat.top_digit == 4'd0 && digits_left > DL_W'(1)) begin
          ctrl.next_digit  = 1'b1;
          digits_left_next = digits_left - 1'b1;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (neg_pending) begin
            load_code        = ASCII_MINUS;
            neg_pending_next = 1'b0;
          end else begin
            load_code        = ASCII_ZERO + CHAR_BITS'(stat.top_digit);
            load_last        = (digits_left == DL_W'(1));
            ctrl.next_digit  = 1'b1;
            digits_left_next = digits_left - 1'b1;
            if (digits_left == DL_W'(1)) begin
              state_next = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      neg_pending <= 1'b0;
      digits_left <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      neg_pending <= neg_pending_next;
      digits_left <= digits_left_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      char_code <= load_code;
      last_char <= load_last;
    end
  end

  assign m_tdata = {{(OUT_W - CHAR_BITS){1'b0}}, char_code};
  assign m_tlast = last_char;

  sitda_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .value (mag_in),
    .stat  (stat)
  );

endmodule

[sv/sitda_checker.sv]
// ----------------------------------------------------------------------------
// sitda_checker
// port-level assertions for the decimal printer, bound to the top level
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_macros.svh"

module sitda_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [sitda_pkg::OUT_W-1:0] m_tdata,
  input logic                        m_tlast
);
  import sitda_pkg::*;

  // a stalled character holds its code and marker
  `SITDA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // only a minus sign or a decimal digit leaves the block
  `SITDA_ASSERT_SAME(a_char_range, m_tvalid,
    m_tdata == OUT_W'(ASCII_MINUS) || (m_tdata >= OUT_W'(ASCII_ZERO) && m_tdata <= OUT_W'(57)))

  // a minus sign is always followed by digits
  `SITDA_ASSERT_SAME(a_sign_not_last, m_tvalid && m_tdata == OUT_W'(ASCII_MINUS), !m_tlast)

  // a number is being converted right after it is taken
  `SITDA_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready)

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_checker (.*);
